[design/constraint_group_colorer_core_assert.svh]
// Assertion macros for the constraint group colorer.
`ifndef CONSTRAINT_GROUP_COLORER_CORE_ASSERT_SVH
`define CONSTRAINT_GROUP_COLORER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define CGC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("cgc: assertion failed");

// Next-cycle implication.
`define CGC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("cgc: assertion failed");

`else

`define CGC_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define CGC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[design/cgc_pkg.sv]
package cgc_pkg;

  localparam int BODY_W          = 10;
  localparam int BCNT_W          = 3;
  localparam int GIDX_W          = 4;
  localparam int GUSE_W          = 5;
  localparam int NUM_BODY_FIELDS = 4;
  localparam int GIDX_MAX_W      = 6;
  localparam int GCNT_MAX_W      = 7;
  localparam int EPOCH_W         = 8;

  typedef logic [EPOCH_W-1:0] epoch_t;

  typedef struct packed {
    logic   rd_en;
    logic   wr_en;
    epoch_t wr_tag;
    epoch_t cur_tag;
  } lane_ctrl_t;

  typedef struct packed {
    logic                  found;
    logic                  opened;
    logic                  ovf;
    logic [GIDX_MAX_W-1:0] chosen;
    logic [GCNT_MAX_W-1:0] count;
  } merge_res_t;

endpackage

[design/cgc_item_if.sv]
interface cgc_item_if;
  logic                         valid;
  logic                         ready;
  logic                         start_new_pass;
  logic [cgc_pkg::BCNT_W-1:0]   body_count;
  logic [cgc_pkg::BODY_W-1:0]   body_a;
  logic [cgc_pkg::BODY_W-1:0]   body_b;
  logic [cgc_pkg::BODY_W-1:0]   body_c;
  logic [cgc_pkg::BODY_W-1:0]   body_d;

  modport source (
    output valid, start_new_pass, body_count, body_a, body_b, body_c, body_d,
    input  ready
  );
  modport sink (
    input  valid, start_new_pass, body_count, body_a, body_b, body_c, body_d,
    output ready
  );
endinterface

interface cgc_result_if;
  logic                         valid;
  logic                         ready;
  logic [cgc_pkg::GIDX_W-1:0]   group_index;
  logic                         opened_new_group;
  logic                         overflow;
  logic [cgc_pkg::GUSE_W-1:0]   groups_in_use;

  modport source (
    output valid, group_index, opened_new_group, overflow, groups_in_use,
    input  ready
  );
  modport sink (
    input  valid, group_index, opened_new_group, overflow, groups_in_use,
    output ready
  );
endinterface

[design/cgc_lane.sv]
module cgc_lane #(
  parameter int MAX_BODIES = 1024,
  parameter int MAX_GROUPS = 16
) (
  input  logic                          clk_i,
  input  cgc_pkg::lane_ctrl_t           ctrl_i,
  input  logic [$clog2(MAX_BODIES)-1:0] rd_addr_i,
  input  logic [$clog2(MAX_BODIES)-1:0] wr_addr_i,
  input  logic [MAX_GROUPS-1:0]         wr_mask_i,
  output logic [MAX_GROUPS-1:0]         mask_o
);
  import cgc_pkg::*;

  typedef struct packed {
    epoch_t                tag;
    logic [MAX_GROUPS-1:0] mask;
  } entry_t;

  entry_t mem_q [MAX_BODIES];
  entry_t rd_q;

  // single port: write wins
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[wr_addr_i] <= '{tag: ctrl_i.wr_tag, mask: wr_mask_i};
    end else if (ctrl_i.rd_en) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  // stale epoch reads as empty
  assign mask_o = (rd_q.tag == ctrl_i.cur_tag) ? rd_q.mask : '0;

endmodule

[design/cgc_merge.sv]
`include "constraint_group_colorer_core_assert.svh"

module cgc_merge #(
  parameter int MAX_GROUPS = 16,
  parameter int LANES      = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  clear_i,
  input  logic                  go_i,
  input  logic [MAX_GROUPS-1:0] masks_i [LANES],
  input  logic [LANES-1:0]      use_i,
  output cgc_pkg::merge_res_t   res_o
);
  import cgc_pkg::*;

  localparam int CW = $clog2(MAX_GROUPS + 1);

  logic [CW-1:0]         count_q, count_d;
  logic [MAX_GROUPS-1:0] used, free;
  logic [GIDX_MAX_W-1:0] pick;
  merge_res_t            res_q, res_d;

  always_comb begin
    used = '0;
    for (int k = 0; k < LANES; k++) begin
      if (use_i[k]) used = used | masks_i[k];
    end
    for (int g = 0; g < MAX_GROUPS; g++) begin
      free[g] = !used[g] && (g < int'(count_q));
    end
    pick = '0;
    for (int g = MAX_GROUPS - 1; g >= 0; g--) begin
      if (free[g]) pick = GIDX_MAX_W'(g);
    end
  end

  always_comb begin
    count_d = count_q;
    res_d   = '0;
    if (|free) begin
      res_d.found  = 1'b1;
      res_d.chosen = pick;
    end else if (count_q < CW'(MAX_GROUPS)) begin
      res_d.found  = 1'b1;
      res_d.opened = 1'b1;
      res_d.chosen = GIDX_MAX_W'(count_q);
      count_d      = count_q + CW'(1);
    end else begin
      res_d.ovf = 1'b1;
    end
    res_d.count = GCNT_MAX_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (clear_i) begin
      count_q <= '0;
    end else if (go_i) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

  `CGC_ASSERT_NEXT(a_found_xor_ovf, clk_i, rst_ni, go_i, res_q.found != res_q.ovf)
  `CGC_ASSERT_NEXT(a_chosen_open, clk_i, rst_ni, go_i, res_q.ovf || (GCNT_MAX_W'(res_q.chosen) < res_q.count))

endmodule

[design/constraint_group_colorer_core.sv]
// Channel  Dir  Modport               Payload
// in_i     in   cgc_item_if.sink      start_new_pass, body_count, body_a..body_d
// out_o    out  cgc_result_if.source  group_index, opened_new_group, overflow, groups_in_use
//
// One item at a time: accept, lane read, merge, one write step per body slot up to
// the body count capped at LANES, then load of the result register.
// Each lane keeps its own copy of the mask table on a single-port memory; the
// write cycles update every copy, one body per cycle.
// After reset a clearing pass over all MAX_BODIES entries runs with in_i.ready low;
// new passes bump an 8-bit epoch, and every 255th new pass reruns that sweep.
// A waiting result does not block the next accept; only the load waits.
`include "constraint_group_colorer_core_assert.svh"

module constraint_group_colorer_core #(
  parameter int MAX_BODIES      = 1024,
  parameter int MAX_GROUPS      = 16,
  parameter int BODIES_PER_ITEM = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  cgc_item_if.sink      in_i,
  cgc_result_if.source  out_o
);
  import cgc_pkg::*;

  localparam int LANES = (BODIES_PER_ITEM < NUM_BODY_FIELDS) ? BODIES_PER_ITEM
                                                             : NUM_BODY_FIELDS;
  localparam int AW    = $clog2(MAX_BODIES);
  localparam int LW    = (LANES > 1) ? $clog2(LANES) : 1;

  typedef enum logic [5:0] {
    S_SWEEP = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_MERGE = 6'b001000,
    S_WRITE = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e                state_q, state_d;
  logic [AW-1:0]         sw_q, sw_d;
  epoch_t                epoch_q, epoch_d;
  logic                  busy_q, busy_d;
  logic [LW-1:0]         wr_k_q, wr_k_d;
  logic [BCNT_W-1:0]     n_q;
  logic [LANES-1:0]      use_q;
  logic [BODY_W-1:0]     body_q [LANES];

  logic                  out_valid_q;
  logic [GIDX_W-1:0]     gidx_q;
  logic                  opened_q;
  logic                  ovf_q;
  logic [GUSE_W-1:0]     guse_q;

  logic [BODY_W-1:0]     in_body [NUM_BODY_FIELDS];
  logic [BCNT_W-1:0]     in_n;
  logic                  accept;
  logic                  load;
  logic                  merge_go;
  logic                  merge_clr;
  lane_ctrl_t            lane_ctrl;
  logic [AW-1:0]         wr_addr;
  logic [MAX_GROUPS-1:0] wr_mask;
  logic [MAX_GROUPS-1:0] lane_mask [LANES];
  merge_res_t            res;

  assign in_body[0] = in_i.body_a;
  assign in_body[1] = in_i.body_b;
  assign in_body[2] = in_i.body_c;
  assign in_body[3] = in_i.body_d;

  assign in_n = (in_i.body_count > BCNT_W'(LANES)) ? BCNT_W'(LANES) : in_i.body_count;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign load       = (state_q == S_DONE) && (!out_valid_q || out_o.ready);
  assign merge_go   = (state_q == S_MERGE);
  assign merge_clr  = accept && in_i.start_new_pass;

  always_comb begin
    state_d = state_q;
    sw_d    = sw_q;
    epoch_d = epoch_q;
    busy_d  = busy_q;
    wr_k_d  = wr_k_q;
    unique case (state_q)
      S_SWEEP: begin
        sw_d = sw_q + AW'(1);
        if (sw_q == AW'(MAX_BODIES - 1)) begin
          sw_d    = '0;
          epoch_d = EPOCH_W'(1);
          state_d = busy_q ? S_READ : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          busy_d  = 1'b1;
          state_d = S_READ;
          if (in_i.start_new_pass) begin
            if (epoch_q == '1) state_d = S_SWEEP;
            else               epoch_d = epoch_q + EPOCH_W'(1);
          end
        end
      end
      S_READ: state_d = S_MERGE;
      S_MERGE: begin
        wr_k_d  = '0;
        state_d = (n_q == '0) ? S_DONE : S_WRITE;
      end
      S_WRITE: begin
        wr_k_d = wr_k_q + LW'(1);
        if (BCNT_W'(wr_k_q) + BCNT_W'(1) == n_q) state_d = S_DONE;
      end
      S_DONE: begin
        if (load) begin
          busy_d  = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_SWEEP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      sw_q        <= '0;
      epoch_q     <= EPOCH_W'(1);
      busy_q      <= 1'b0;
      wr_k_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sw_q    <= sw_d;
      epoch_q <= epoch_d;
      busy_q  <= busy_d;
      wr_k_q  <= wr_k_d;
      if (load)              out_valid_q <= 1'b1;
      else if (out_o.ready)  out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      n_q <= in_n;
      for (int k = 0; k < LANES; k++) begin
        body_q[k] <= in_body[k];
        use_q[k]  <= (BCNT_W'(k) < in_n) && (32'(in_body[k]) < 32'(MAX_BODIES));
      end
    end
    if (load) begin
      gidx_q   <= res.ovf ? '0 : res.chosen[GIDX_W-1:0];
      opened_q <= res.opened;
      ovf_q    <= res.ovf;
      guse_q   <= res.count[GUSE_W-1:0];
    end
  end

  always_comb begin
    lane_ctrl.rd_en   = (state_q == S_READ);
    lane_ctrl.wr_en   = (state_q == S_SWEEP) ||
                        ((state_q == S_WRITE) && use_q[wr_k_q] && res.found);
    lane_ctrl.wr_tag  = (state_q == S_SWEEP) ? '0 : epoch_q;
    lane_ctrl.cur_tag = epoch_q;
    if (state_q == S_SWEEP) begin
      wr_addr = sw_q;
      wr_mask = '0;
    end else begin
      wr_addr = AW'(body_q[wr_k_q]);
      wr_mask = lane_mask[wr_k_q] | (MAX_GROUPS'(1) << res.chosen);
    end
  end

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    cgc_lane #(
      .MAX_BODIES (MAX_BODIES),
      .MAX_GROUPS (MAX_GROUPS)
    ) u_lane (
      .clk_i     (clk_i),
      .ctrl_i    (lane_ctrl),
      .rd_addr_i (AW'(body_q[k])),
      .wr_addr_i (wr_addr),
      .wr_mask_i (wr_mask),
      .mask_o    (lane_mask[k])
    );
  end

  cgc_merge #(
    .MAX_GROUPS (MAX_GROUPS),
    .LANES      (LANES)
  ) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (merge_clr),
    .go_i    (merge_go),
    .masks_i (lane_mask),
    .use_i   (use_q),
    .res_o   (res)
  );

  assign out_o.valid            = out_valid_q;
  assign out_o.group_index      = gidx_q;
  assign out_o.opened_new_group = opened_q;
  assign out_o.overflow         = ovf_q;
  assign out_o.groups_in_use    = guse_q;

  `CGC_ASSERT_IMPL(a_ovf_fields, clk_i, rst_ni, out_o.valid && out_o.overflow,
                   (out_o.group_index == '0) && !out_o.opened_new_group)
  `CGC_ASSERT_IMPL(a_open_count, clk_i, rst_ni, out_o.valid && out_o.opened_new_group,
                   out_o.groups_in_use[GIDX_W-1:0] == out_o.group_index + GIDX_W'(1))
  `CGC_ASSERT_IMPL(a_write_range, clk_i, rst_ni, state_q == S_WRITE, BCNT_W'(wr_k_q) < n_q)

endmodule

[sim/constraint_group_colorer_core_tb.sv]
typedef struct packed {
  logic                       start_new_pass;
  logic [cgc_pkg::BCNT_W-1:0] body_count;
  logic [cgc_pkg::BODY_W-1:0] body_a;
  logic [cgc_pkg::BODY_W-1:0] body_b;
  logic [cgc_pkg::BODY_W-1:0] body_c;
  logic [cgc_pkg::BODY_W-1:0] body_d;
} coloring_req_t;

typedef struct packed {
  logic [cgc_pkg::GIDX_W-1:0] group_index;
  logic                       opened_new_group;
  logic                       overflow;
  logic [cgc_pkg::GUSE_W-1:0] groups_in_use;
} coloring_res_t;

class group_coloring_sb #(int NUM_BODIES = 1024, int NUM_GROUPS = 16, int BODY_SLOTS = 4);
  logic [NUM_GROUPS-1:0] body_masks [NUM_BODIES];
  int unsigned           open_groups;
  coloring_res_t         pending_groupings [$];
  int unsigned           err_cnt, n_constraints, n_results, n_opened, n_overflows, n_passes;

  function new();
    clear_masks();
    err_cnt       = 0;
    n_constraints = 0;
    n_results     = 0;
    n_opened      = 0;
    n_overflows   = 0;
    n_passes      = 0;
  endfunction

  function void clear_masks();
    foreach (body_masks[i]) body_masks[i] = '0;
    open_groups = 0;
  endfunction

  // Greedy pick of the lowest open group free for all bodies of the item, else a new group or overflow.
  function void note_constraint(coloring_req_t req);
    logic [cgc_pkg::BODY_W-1:0] bodies [4];
    logic [NUM_GROUPS-1:0]      used;
    int unsigned                n_used, chosen;
    bit                         found, opened, ovf;
    coloring_res_t              exp_res;
    bodies[0] = req.body_a;
    bodies[1] = req.body_b;
    bodies[2] = req.body_c;
    bodies[3] = req.body_d;
    n_constraints++;
    if (req.start_new_pass) begin
      clear_masks();
      n_passes++;
    end
    n_used = 32'(req.body_count);
    if (n_used > BODY_SLOTS) n_used = BODY_SLOTS;
    if (n_used > 4) n_used = 4;
    used   = '0;
    found  = 1'b0;
    opened = 1'b0;
    ovf    = 1'b0;
    chosen = 0;
    for (int k = 0; k < n_used; k++) begin
      if (bodies[k] < NUM_BODIES) used |= body_masks[bodies[k]];
    end
    for (int g = 0; g < open_groups; g++) begin
      if (!found && !used[g]) begin
        chosen = g;
        found  = 1'b1;
      end
    end
    if (!found) begin
      if (open_groups < NUM_GROUPS) begin
        chosen = open_groups;
        open_groups++;
        opened = 1'b1;
        found  = 1'b1;
      end else begin
        ovf = 1'b1;
      end
    end
    if (found) begin
      for (int k = 0; k < n_used; k++) begin
        if (bodies[k] < NUM_BODIES) body_masks[bodies[k]][chosen] = 1'b1;
      end
    end
    exp_res.group_index      = ovf ? '0 : chosen[cgc_pkg::GIDX_W-1:0];
    exp_res.opened_new_group = opened;
    exp_res.overflow         = ovf;
    exp_res.groups_in_use    = open_groups[cgc_pkg::GUSE_W-1:0];
    pending_groupings.insert(pending_groupings.size(), exp_res);
  endfunction

  function void check_grouping(coloring_res_t act);
    coloring_res_t exp_res;
    if (pending_groupings.size() == 0) begin
      err_cnt++;
      $display("%0t: ERROR unexpected result, expected none, got group_index %0d overflow %0d",
               $time, act.group_index, act.overflow);
      return;
    end
    exp_res = pending_groupings.pop_front();
    n_results++;
    if (exp_res.opened_new_group) n_opened++;
    if (exp_res.overflow) n_overflows++;
    if (act.group_index !== exp_res.group_index) begin
      err_cnt++;
      $display("%0t: ERROR group_index expected %0d, got %0d",
               $time, exp_res.group_index, act.group_index);
    end
    if (act.opened_new_group !== exp_res.opened_new_group) begin
      err_cnt++;
      $display("%0t: ERROR opened_new_group expected %0d, got %0d",
               $time, exp_res.opened_new_group, act.opened_new_group);
    end
    if (act.overflow !== exp_res.overflow) begin
      err_cnt++;
      $display("%0t: ERROR overflow expected %0d, got %0d",
               $time, exp_res.overflow, act.overflow);
    end
    if (act.groups_in_use !== exp_res.groups_in_use) begin
      err_cnt++;
      $display("%0t: ERROR groups_in_use expected %0d, got %0d",
               $time, exp_res.groups_in_use, act.groups_in_use);
    end
  endfunction
endclass

module constraint_group_colorer_core_tb;
  localparam int MAX_BODIES      = 1024;
  localparam int MAX_GROUPS      = 16;
  localparam int BODIES_PER_ITEM = 4;
  // covers the post-reset clear sweep plus the longest stall
  localparam int WATCHDOG_LIMIT  = 8000;
  localparam int SETTLE_CYCLES   = 32;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  bit          gaps_on, stalls_on;
  int unsigned stall_left  = 0;
  int unsigned idle_cycles = 0;

  group_coloring_sb #(MAX_BODIES, MAX_GROUPS, BODIES_PER_ITEM) sb;

  cgc_item_if   in_if ();
  cgc_result_if out_if ();

  constraint_group_colorer_core #(
    .MAX_BODIES      (MAX_BODIES),
    .MAX_GROUPS      (MAX_GROUPS),
    .BODIES_PER_ITEM (BODIES_PER_ITEM)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #1 clk_i = ~clk_i;

  // result backpressure: mostly short stalls, a few long ones
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (stalls_on && $urandom_range(0, 99) < 20) begin
      out_if.ready <= 1'b0;
      stall_left   <= ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2)
                                                   : $urandom_range(10, 40);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        sb.note_constraint('{in_if.start_new_pass, in_if.body_count, in_if.body_a,
                             in_if.body_b, in_if.body_c, in_if.body_d});
      end
      if (out_if.valid && out_if.ready) begin
        sb.check_grouping('{out_if.group_index, out_if.opened_new_group,
                            out_if.overflow, out_if.groups_in_use});
      end
    end
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, no item moved for %0d cycles", $time, idle_cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic coloring_req_t mk_req(bit np, int unsigned cnt, int unsigned a,
                                           int unsigned b, int unsigned c, int unsigned d);
    coloring_req_t r;
    r.start_new_pass = np;
    r.body_count     = cnt[cgc_pkg::BCNT_W-1:0];
    r.body_a         = a[cgc_pkg::BODY_W-1:0];
    r.body_b         = b[cgc_pkg::BODY_W-1:0];
    r.body_c         = c[cgc_pkg::BODY_W-1:0];
    r.body_d         = d[cgc_pkg::BODY_W-1:0];
    return r;
  endfunction

  // bodies mostly from a narrow window so groups collide; unused slots get noise
  function automatic coloring_req_t rand_req(int unsigned base, int unsigned pool);
    int unsigned sel, cnt;
    int unsigned b [4];
    sel = $urandom_range(0, 99);
    if (sel < 4) cnt = 0;
    else if (sel < 9) cnt = $urandom_range(5, 7);
    else cnt = $urandom_range(1, 4);
    for (int k = 0; k < 4; k++) begin
      if (k < cnt && $urandom_range(0, 19) != 0)
        b[k] = base + $urandom_range(0, pool - 1);
      else
        b[k] = $urandom_range(0, MAX_BODIES - 1);
    end
    return mk_req(1'b0, cnt, b[0], b[1], b[2], b[3]);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned sel;
    if (!gaps_on) return 0;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  task automatic send_req(coloring_req_t req);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    in_if.valid          <= 1'b1;
    in_if.start_new_pass <= req.start_new_pass;
    in_if.body_count     <= req.body_count;
    in_if.body_a         <= req.body_a;
    in_if.body_b         <= req.body_b;
    in_if.body_c         <= req.body_c;
    in_if.body_d         <= req.body_d;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (gap != 0) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (sb.pending_groupings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_passes(int unsigned target, int unsigned max_len, int unsigned start_pct);
    int unsigned   sent, len, pool, base;
    coloring_req_t req;
    sent = 0;
    while (sent < target) begin
      len  = $urandom_range(1, max_len);
      pool = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 6);
      base = $urandom_range(0, MAX_BODIES - pool);
      for (int i = 0; i < len; i++) begin
        req = rand_req(base, pool);
        req.start_new_pass = (i == 0 && $urandom_range(0, 99) < start_pct) ||
                             ($urandom_range(0, 99) < 2);
        send_req(req);
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni               = 1'b0;
    in_if.valid          = 1'b0;
    in_if.start_new_pass = 1'b0;
    in_if.body_count     = '0;
    in_if.body_a         = '0;
    in_if.body_b         = '0;
    in_if.body_c         = '0;
    in_if.body_d         = '0;
    out_if.ready         = 1'b0;
    gaps_on              = 1'b0;
    stalls_on            = 1'b0;
    sb                   = new();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_req(mk_req(1'b1, 1, 0, 0, 0, 0));
    send_req(mk_req(1'b0, 1, 1023, 0, 0, 0));
    send_req(mk_req(1'b0, 4, 0, 1023, 512, 511));
    send_req(mk_req(1'b0, 0, 1023, 1023, 1023, 1023));
    // oversized count, same body in every slot
    send_req(mk_req(1'b0, 7, 0, 0, 0, 0));
    send_req(mk_req(1'b0, 5, 1, 2, 3, 4));
    send_req(mk_req(1'b0, 6, 682, 341, 682, 1023));
    // empty item opens group 0 on a fresh pass
    send_req(mk_req(1'b1, 0, 5, 6, 7, 8));
    // one shared body fills all groups, then overflows
    send_req(mk_req(1'b1, 2, 341, 682, 0, 0));
    for (int i = 0; i < MAX_GROUPS; i++) send_req(mk_req(1'b0, 1, 341, 0, 0, 0));
    send_req(mk_req(1'b0, 0, 341, 341, 341, 341));
    send_req(mk_req(1'b0, 3, 1022, 1, 1022, 0));
    drain_results();

    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    run_passes(700, 60, 90);
    drain_results();

    // many short passes to roll the pass epoch over
    gaps_on   = 1'b0;
    stalls_on = 1'b1;
    run_passes(390, 2, 100);
    drain_results();

    gaps_on   = 1'b1;
    stalls_on = 1'b0;
    run_passes(100, 40, 90);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    run_passes(100, 40, 90);
    drain_results();

    $display("Covered %0d constraints in %0d passes: %0d results, %0d new groups, %0d overflows.",
             sb.n_constraints, sb.n_passes, sb.n_results, sb.n_opened, sb.n_overflows);
    $display("Body counts 0..7, repeated bodies, epoch rollover and stalls on both sides.");
    if (sb.err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
